// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implications that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked at the same edge as the antecedent
`define ASSERT_SAME(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed at the same edge");

// Consequent checked at the edge after the antecedent
`define ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed one edge later");

// Consequent checked at a later edge than the antecedent, through a ## delay
`define ASSERT_TWO(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
	else $error("check failed two edges later");

`endif

// ----- hdl/bsbn_pkg.sv -----
// ----------------------------------------------------------------------------
// bsbn_pkg
// Widths, item kinds and bit-search helpers for the bitmap set-bit navigator.
// ----------------------------------------------------------------------------
package bsbn_pkg;

	localparam int KIND_W  = 3;
	localparam int WIDX_W  = 10;
	localparam int WORD_W  = 64;
	localparam int ID_W    = 16;
	localparam int CNT_W   = 11;
	localparam int POS_W   = 11;
	localparam int BIT_W   = 6;

	// words that a write beat can address
	localparam int WRITABLE_WORDS = 2 ** WIDX_W;

	localparam logic [POS_W-1:0] WP_WRAP = '1;

	localparam logic [KIND_W-1:0] K_WRITE   = 3'd0;
	localparam logic [KIND_W-1:0] K_FIRST   = 3'd1;
	localparam logic [KIND_W-1:0] K_LAST    = 3'd2;
	localparam logic [KIND_W-1:0] K_SEEK_TO = 3'd3;
	localparam logic [KIND_W-1:0] K_NEXT    = 3'd4;
	localparam logic [KIND_W-1:0] K_PREV    = 3'd5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BIT_W-1:0]  bitpos_t;

	// bits at or above x; x = 64 gives an empty mask
	function automatic word_t mask_ge(input logic [BIT_W:0] x);
		word_t m;
		m = '1;
		return m << x;
	endfunction

	// index of the lowest set bit, 0 when the word is empty
	function automatic bitpos_t lowest_bit(input word_t w);
		word_t   iso;
		bitpos_t idx;
		iso = w & (~w + 1'b1);
		idx = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (iso[j]) begin
				idx = idx | BIT_W'(j);
			end
		end
		return idx;
	endfunction

	// index of the highest set bit, 63 when the word is empty
	function automatic bitpos_t highest_bit(input word_t w);
		word_t rev;
		for (int j = 0; j < WORD_W; j++) begin
			rev[j] = w[WORD_W-1-j];
		end
		return BIT_W'(WORD_W - 1) - lowest_bit(rev);
	endfunction

endpackage

// ----- hdl/bsbn_ifs.sv -----
// ----------------------------------------------------------------------------
// bsbn_in_if / bsbn_out_if
// Valid/ready channels for command beats and cursor result beats.
// ----------------------------------------------------------------------------
interface bsbn_in_if
	import bsbn_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [WIDX_W-1:0] word_index;
	word_t             word_data;
	logic [ID_W-1:0]   target_id;

	modport source (output valid, kind, word_index, word_data, target_id, input ready);
	modport sink (input valid, kind, word_index, word_data, target_id, output ready);
endinterface

interface bsbn_out_if
	import bsbn_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] current_id;
	logic            cursor_valid;

	modport source (output valid, current_id, cursor_valid, input ready);
	modport sink (input valid, current_id, cursor_valid, output ready);
endinterface

// ----- hdl/bsbn_ram.sv -----
// ----------------------------------------------------------------------------
// bsbn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/bitmap_set_bit_navigator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_set_bit_navigator_core
// Bitmap of 64-bit words with a cursor that walks its set bits.
// ----------------------------------------------------------------------------
// cmd carries one beat per operation: write a word, seek first, seek last,
// seek to a target id, next or prev. rsp returns one beat per command with
// the held cursor id and whether the cursor sits on a word in use.
// cfg_wr_en/cfg_wr_data load word_count; write it only while no command is
// outstanding.
// Flow: writes, no-op kinds and next/prev on an invalid cursor go from
// IDLE straight to DONE; next/prev first test the current word in CUR and
// finish from there on a hit. A scan reads one word per cycle from the
// bitmap RAM in SCAN; a seek scans from IDLE and a step that crosses empty
// words goes CUR then SCAN; the worst case is a walk over all effective
// words (word_count limited to MAX_WORDS). One command is worked at a time.
// Reset: the cursor and word_count clear at once, then a clearing pass
// writes zero to every RAM word, one word per cycle; cmd.ready stays low
// during that pass.
// A finished result waits in the output register; the next command is
// taken meanwhile, but it cannot finish until rsp takes the earlier beat.
// ----------------------------------------------------------------------------
module bitmap_set_bit_navigator_core
	import bsbn_pkg::*;
#(
	parameter int MAX_WORDS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	bsbn_in_if.sink          cmd,
	bsbn_out_if.source       rsp
);

	localparam int MEM_DEPTH = (MAX_WORDS < WRITABLE_WORDS) ? MAX_WORDS : WRITABLE_WORDS;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [16:0]  MAXW_V = 17'(MAX_WORDS);
	localparam logic [POS_W:0] MEMD_V = (POS_W + 1)'(MEM_DEPTH);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CUR   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_idx_q;
	logic [CNT_W-1:0]  wc_q;
	logic [KIND_W-1:0] op_q;
	logic [ID_W-1:0]   tgt_q;

	logic              wrap_q;
	logic [POS_W-1:0]  wp_q;
	bitpos_t           bp_q;
	logic              over_q;
	logic [ID_W-1:0]   held_q;

	logic [POS_W-1:0]  iss_idx_q;
	logic              more_q;
	logic              any_q;
	logic [ID_W-1:0]   last_q;

	logic              rd_vld_s1;
	logic              rd_zero_s1;
	logic [POS_W-1:0]  rd_idx_s1;

	logic              rsp_vld_q;
	logic [ID_W-1:0]   rsp_id_q;
	logic              rsp_cv_q;

	logic [POS_W-1:0]  n_eff;
	logic [POS_W:0]    n_ext;
	logic              cur_ok;
	logic              cmd_acc;
	logic              rsp_load;

	logic              rd_en;
	logic [POS_W-1:0]  rd_pos;
	word_t             rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	word_t             wr_data;

	word_t             w;
	word_t             seek_mask;
	word_t             lo_mask;
	word_t             hi_mask;
	word_t             lo_src;
	word_t             hi_src;
	bitpos_t           lo_bit;
	bitpos_t           hi_bit;
	bitpos_t           hit_bit;
	logic              is_down;
	logic              word_hit;
	logic              word_any;
	logic              any_sel;
	logic [ID_W-1:0]   last_sel;
	logic [POS_W:0]    wp_inc;
	logic [POS_W:0]    iss_inc;
	logic [ID_W-1:0]   hit_id;

	// effective word count, limited to MAX_WORDS
	assign n_eff = ({{(17 - CNT_W){1'b0}}, wc_q} > MAXW_V) ? MAXW_V[POS_W-1:0] : wc_q;
	assign n_ext = {1'b0, n_eff};

	assign cur_ok   = !wrap_q && (wp_q < n_eff) && !over_q;
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp_load = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	assign wp_inc  = {1'b0, wp_q} + 1'b1;
	assign iss_inc = {1'b0, iss_idx_q} + 1'b1;

	// bitmap RAM: clearing pass and write beats share the write port
	assign wr_en   = (state_q == ST_CLEAR) ||
			(cmd_acc && (cmd.kind == K_WRITE) && ({1'b0, cmd.word_index} < MEMD_V));
	assign wr_addr = (state_q == ST_CLEAR) ? clr_idx_q : cmd.word_index[AW-1:0];
	assign wr_data = (state_q == ST_CLEAR) ? '0 : cmd.word_data;

	always_comb begin
		rd_en  = 1'b0;
		rd_pos = iss_idx_q;
		if (cmd_acc && ((cmd.kind == K_NEXT) || (cmd.kind == K_PREV)) && cur_ok) begin
			rd_en  = 1'b1;
			rd_pos = wp_q;
		end else if ((state_q == ST_SCAN) && !word_hit && more_q) begin
			rd_en = 1'b1;
		end
	end

	bsbn_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_DEPTH),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_pos[AW-1:0]),
		.rdata (rd_data)
	);

	// words beyond the RAM never get written and read as zero
	assign w = rd_zero_s1 ? '0 : rd_data;

	always_comb begin
		if (rd_idx_s1 > {1'b0, tgt_q[ID_W-1:BIT_W]}) begin
			seek_mask = '1;
		end else if (rd_idx_s1 == {1'b0, tgt_q[ID_W-1:BIT_W]}) begin
			seek_mask = mask_ge({1'b0, tgt_q[BIT_W-1:0]});
		end else begin
			seek_mask = '0;
		end
	end

	// in the cursor word, search strictly above or below the bit position
	assign lo_mask = (state_q == ST_CUR) ? mask_ge({1'b0, bp_q} + 1'b1) :
			(op_q == K_SEEK_TO) ? seek_mask : '1;
	assign hi_mask = (state_q == ST_CUR) ? ~mask_ge({1'b0, bp_q}) : '1;
	assign lo_src  = w & lo_mask;
	assign hi_src  = w & hi_mask;
	assign lo_bit  = lowest_bit(lo_src);
	assign hi_bit  = highest_bit(hi_src);

	assign is_down  = (op_q == K_LAST) || (op_q == K_PREV);
	assign word_hit = rd_vld_s1 && (is_down ? (|hi_src) : (|lo_src));
	assign word_any = rd_vld_s1 && (|w);
	assign hit_bit  = is_down ? hi_bit : lo_bit;
	assign hit_id   = {rd_idx_s1[ID_W-BIT_W-1:0], hit_bit};

	// seek-to keeps the last set bit below the target
	assign any_sel  = any_q || word_any;
	assign last_sel = word_any ? {rd_idx_s1[ID_W-BIT_W-1:0], hi_bit} : last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1  <= rd_pos;
			rd_zero_s1 <= ({1'b0, rd_pos} >= MEMD_V);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
		end else if (cfg_wr_en) begin
			wc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			wrap_q    <= 1'b0;
			wp_q      <= '0;
			bp_q      <= '0;
			over_q    <= 1'b0;
			held_q    <= '0;
			more_q    <= 1'b0;
			any_q     <= 1'b0;
			op_q      <= K_WRITE;
			tgt_q     <= '0;
			iss_idx_q <= '0;
			last_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_acc) begin
						op_q  <= cmd.kind;
						tgt_q <= cmd.target_id;
						any_q <= 1'b0;
						case (cmd.kind) inside
							K_FIRST, K_SEEK_TO: begin
								iss_idx_q <= '0;
								more_q    <= (n_eff != '0);
								state_q   <= ST_SCAN;
							end
							K_LAST: begin
								iss_idx_q <= n_eff - 1'b1;
								more_q    <= 1'b1;
								state_q   <= (n_eff != '0) ? ST_SCAN : ST_DONE;
							end
							K_NEXT, K_PREV: begin
								state_q <= cur_ok ? ST_CUR : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CUR: begin
					if (word_hit) begin
						bp_q    <= hit_bit;
						held_q  <= {wp_q[ID_W-BIT_W-1:0], hit_bit};
						state_q <= ST_DONE;
					end else if (op_q == K_NEXT) begin
						iss_idx_q <= wp_inc[POS_W-1:0];
						more_q    <= (wp_inc < n_ext);
						state_q   <= ST_SCAN;
					end else begin
						iss_idx_q <= wp_q - 1'b1;
						more_q    <= (wp_q != '0);
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (word_hit) begin
						wrap_q  <= 1'b0;
						wp_q    <= rd_idx_s1;
						bp_q    <= hit_bit;
						over_q  <= 1'b0;
						held_q  <= hit_id;
						state_q <= ST_DONE;
					end else if (more_q) begin
						// advance one word per cycle
						if (is_down) begin
							iss_idx_q <= iss_idx_q - 1'b1;
							more_q    <= (iss_idx_q != '0);
						end else begin
							iss_idx_q <= iss_inc[POS_W-1:0];
							more_q    <= (iss_inc < n_ext);
						end
						any_q  <= any_sel;
						last_q <= last_sel;
					end else begin
						// ran out of words
						case (op_q) inside
							K_FIRST: begin
								wrap_q <= 1'b0;
								wp_q   <= n_eff;
							end
							K_SEEK_TO: begin
								wrap_q <= 1'b0;
								wp_q   <= n_eff;
								if (any_sel) begin
									over_q <= 1'b1;
									held_q <= last_sel;
								end
							end
							K_NEXT: begin
								wp_q   <= n_eff;
								over_q <= 1'b1;
							end
							K_LAST: begin
								wrap_q <= 1'b1;
								wp_q   <= WP_WRAP;
							end
							default: begin
								wrap_q <= 1'b1;
								wp_q   <= WP_WRAP;
								over_q <= 1'b1;
							end
						endcase
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_id_q <= held_q;
			rsp_cv_q <= cur_ok;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.current_id   = rsp_id_q;
	assign rsp.cursor_valid = rsp_cv_q;

endmodule

// ----- hdl/bsbn_check.sv -----
// ----------------------------------------------------------------------------
// bsbn_check
// Port-level checks for the navigator core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsbn_check
	import bsbn_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [KIND_W-1:0] cmd_kind,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [ID_W-1:0]   current_id,
	input logic              cursor_valid
);

	logic cmd_acc;
	logic rsp_stall;

	assign cmd_acc   = cmd_valid && cmd_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	// a stalled result beat holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(current_id) && $stable(cursor_valid))

	// one command at a time: ready drops after each accepted beat
	`ASSERT_NEXT(a_cmd_single, clk, arst_n, cmd_acc, !cmd_ready)

	// a write beat with the output free answers through DONE and the output register
	`ASSERT_TWO(a_write_lat, clk, arst_n, cmd_acc && (cmd_kind == K_WRITE) && !rsp_valid, rsp_valid)

endmodule

bind bitmap_set_bit_navigator_core bsbn_check u_bsbn_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_kind     (cmd.kind),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.current_id   (rsp.current_id),
	.cursor_valid (rsp.cursor_valid)
);
